FILE: rtl/ffms_pkg.sv
package ffms_pkg;

  // Field widths
  localparam int SAMPLE_W = 32;
  // Running sum of up to 64 samples of 32 bits
  localparam int SUM_W    = 38;
  // Signed difference count*x - sum, and its magnitude
  localparam int DIFF_W   = 40;
  localparam int DEV_W    = 39;

  // One input item
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       end_of_set;
  } sample_in_t;

  // One result item
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] chosen_value;
    logic                       end_of_run;
    logic                       truncated;
  } result_t;

endpackage

FILE: rtl/ffms_ram.sv
module ffms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/farthest_from_mean_select_core.sv
// Channel   Handshake                Payload       Direction
// item      start && !busy           sample_in_t   in
// result    result_strobe (1 cycle)  result_t      out
//
// Loading: one item per cycle while busy is low; each kept sample is written
// to the sample memory and added to the running sum.
// Selection: after the item with end_of_set, busy stays high for two passes
// over the kept samples through the single read port of the sample memory,
// each followed by the four-stage deviation pipeline drain.
// Results leave one per cycle at most, in arrival order; the receiver cannot
// stall them. Reset (rst, synchronous) empties the set; memory needs no clearing.
module farthest_from_mean_select_core import ffms_pkg::*; #(
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  sample_in_t item,
  output logic       busy,
  output result_t    result,
  output logic       result_strobe
);

  localparam int PROD_W = CW + SAMPLE_W + 1;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_MAX  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]              state;
  logic [CW-1:0]           count;
  logic signed [SUM_W-1:0] sum;
  logic                    overflowed;
  logic [CW-1:0]           issue_idx;
  logic [DEV_W-1:0]        best;
  logic [AW-1:0]           last_idx;

  // Deviation pipeline: read, product, difference, magnitude
  logic                     v1, v2, v3, v4;
  logic [AW-1:0]            idx1, idx2, idx3, idx4;
  logic signed [SAMPLE_W-1:0] x2, x3, x4;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic [DEV_W-1:0]         mag_r;
  logic [SAMPLE_W-1:0]      rd_data;
  logic signed [SAMPLE_W-1:0] x1;

  logic in_take, wr_en, scanning, issuing, pass_done, hit;

  assign busy      = (state != ST_LOAD);
  assign in_take   = start && !busy;
  assign wr_en     = in_take && (count < CW'(DEPTH));
  assign scanning  = (state == ST_MAX) || (state == ST_EMIT);
  assign issuing   = scanning && (issue_idx < count);
  assign pass_done = scanning && !issuing && !v1 && !v2 && !v3 && !v4;
  assign hit       = v4 && (mag_r == best);
  assign x1        = $signed(rd_data);

  ffms_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(count[AW-1:0]),
    .wdata(item.sample),
    .raddr(issue_idx[AW-1:0]),
    .rdata(rd_data)
  );

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= issuing;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Pipeline payload: count*x, then count*x - sum, then |.|
  always_ff @(posedge clk) begin
    idx1   <= issue_idx[AW-1:0];
    idx2   <= idx1;
    idx3   <= idx2;
    idx4   <= idx3;
    x2     <= x1;
    x3     <= x2;
    x4     <= x3;
    prod_r <= $signed({1'b0, count}) * x1;
    diff_r <= DIFF_W'(prod_r) - DIFF_W'(sum);
    mag_r  <= diff_r[DIFF_W-1] ? DEV_W'(-diff_r) : DEV_W'(diff_r);
  end

  // Control: load, max pass, emit pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      count      <= '0;
      sum        <= '0;
      overflowed <= 1'b0;
      issue_idx  <= '0;
      best       <= '0;
      last_idx   <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_take) begin
            if (wr_en) begin
              sum   <= sum + SUM_W'(item.sample);
              count <= count + 1'b1;
            end else begin
              overflowed <= 1'b1;
            end
            if (item.end_of_set) begin
              state     <= ST_MAX;
              issue_idx <= '0;
              best      <= '0;
            end
          end
        end
        ST_MAX: begin
          if (issuing) begin
            issue_idx <= issue_idx + 1'b1;
          end
          // Track maximum and the last sample reaching it
          if (v4) begin
            if (mag_r > best) begin
              best     <= mag_r;
              last_idx <= idx4;
            end else if (mag_r == best) begin
              last_idx <= idx4;
            end
          end
          if (pass_done) begin
            state     <= ST_EMIT;
            issue_idx <= '0;
          end
        end
        ST_EMIT: begin
          if (issuing) begin
            issue_idx <= issue_idx + 1'b1;
          end
          if (pass_done) begin
            state      <= ST_LOAD;
            count      <= '0;
            sum        <= '0;
            overflowed <= 1'b0;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (state == ST_EMIT) && hit;
    end
  end

  always_ff @(posedge clk) begin
    result.chosen_value <= x4;
    result.end_of_run   <= (idx4 == last_idx);
    result.truncated    <= overflowed;
  end

  // Checks
  a_strobe_from_emit: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> ($past(state) == ST_EMIT))
    else $error("result strobe outside emit pass");

  a_nonempty_select: assert property (@(posedge clk) disable iff (rst)
    (state != ST_LOAD) |-> (count != '0))
    else $error("selection over an empty set");

  a_last_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.end_of_run) |=> !result_strobe)
    else $error("result item after end of run");

  a_cleared_after_emit: assert property (@(posedge clk) disable iff (rst)
    (($past(state) == ST_EMIT) && (state == ST_LOAD)) |->
      ((count == '0) && (sum == '0) && !overflowed))
    else $error("set state not cleared after emit pass");

endmodule

FILE: tb/sv/farthest_from_mean_select_core_tb.sv
`timescale 1ns / 1ps

module farthest_from_mean_select_core_tb;
  import ffms_pkg::*;

  localparam int DEPTH = 64;

  typedef logic signed [SAMPLE_W-1:0] sample_word_t;

  localparam sample_word_t S_MIN = 32'sh8000_0000;
  localparam sample_word_t S_MAX = 32'sh7fff_ffff;

  // Value flavors for random sets
  typedef enum int {
    MIX_FULL,
    MIX_NARROW,
    MIX_EXTREME,
    MIX_BLEND
  } value_mix_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  sample_in_t item = '0;
  logic       busy;
  result_t    result;
  logic       result_strobe;

  farthest_from_mean_select_core #(.DEPTH(DEPTH)) uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .item          (item),
    .busy          (busy),
    .result        (result),
    .result_strobe (result_strobe)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow of the set being collected
  sample_word_t kept_samples[$];
  longint       set_sum = 0;
  bit           set_dropped = 1'b0;

  // Chosen samples still to come out of the block
  result_t chosen_queue[$];

  int  error_count = 0;
  bit  gaps_on = 1'b0;
  int  random_items = 0;

  // Fold one accepted item into the shadow set; on the last one, predict
  // every sample at maximal |n*x - sum| in arrival order.
  function automatic void absorb_sample(sample_word_t value, logic last);
    longint  n;
    longint  dev;
    longint  widest;
    int      last_idx;
    result_t want;
    if (kept_samples.size() < DEPTH) begin
      kept_samples.push_back(value);
      set_sum += longint'(value);
    end else begin
      set_dropped = 1'b1;
    end
    if (!last) return;
    n = kept_samples.size();
    widest = 0;
    last_idx = -1;
    foreach (kept_samples[i]) begin
      dev = n * longint'(kept_samples[i]) - set_sum;
      if (dev < 0) dev = -dev;
      if (dev > widest) widest = dev;
    end
    foreach (kept_samples[i]) begin
      dev = n * longint'(kept_samples[i]) - set_sum;
      if (dev < 0) dev = -dev;
      if (dev == widest) last_idx = i;
    end
    foreach (kept_samples[i]) begin
      dev = n * longint'(kept_samples[i]) - set_sum;
      if (dev < 0) dev = -dev;
      if (dev == widest) begin
        want.chosen_value = kept_samples[i];
        want.end_of_run   = (i == last_idx);
        want.truncated    = set_dropped;
        chosen_queue.push_back(want);
      end
    end
    kept_samples.delete();
    set_sum = 0;
    set_dropped = 1'b0;
  endfunction

  function automatic void flag_error(string msg);
    if (error_count < 10) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endfunction

  // Send one item; returns once the block has taken it
  task automatic send_sample(sample_word_t value, logic last);
    int gap;
    gap = gaps_on ? $urandom_range(0, 15) : 0;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    item  <= '{sample: value, end_of_set: last};
    do @(posedge clk); while (busy);
    absorb_sample(value, last);
  endtask

  task automatic send_set(sample_word_t vals[$]);
    foreach (vals[i]) send_sample(vals[i], i == vals.size() - 1);
  endtask

  function automatic sample_word_t draw_sample(value_mix_t mix);
    value_mix_t pick;
    pick = (mix == MIX_BLEND) ? value_mix_t'($urandom_range(0, 2)) : mix;
    case (pick)
      MIX_NARROW: begin
        return sample_word_t'($signed($urandom_range(0, 8)) - 4);
      end
      MIX_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return S_MIN;
          1: return S_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      default: begin
        return sample_word_t'($urandom);
      end
    endcase
  endfunction

  task automatic send_random_set(int len);
    value_mix_t mix;
    mix = value_mix_t'($urandom_range(0, 3));
    gaps_on = ($urandom_range(0, 2) != 0);
    for (int i = 0; i < len; i++) send_sample(draw_sample(mix), i == len - 1);
    random_items += len;
  endtask

  // Directed: one-sample sets at both ends of the range
  task automatic test_single_extremes();
    gaps_on = 1'b0;
    send_set('{S_MIN});
    send_set('{S_MAX});
  endtask

  // Directed: min and max lie equally far from their mean, both come out;
  // then a lopsided set where max stands alone
  task automatic test_extreme_pair_tie();
    gaps_on = 1'b1;
    send_set('{S_MIN, S_MAX});
    send_set('{S_MIN, S_MIN, S_MIN, S_MAX});
  endtask

  // Directed: every sample equals the mean, so all of them tie
  task automatic test_all_equal();
    gaps_on = 1'b0;
    send_set('{sample_word_t'(5), sample_word_t'(5), sample_word_t'(5), sample_word_t'(5)});
  endtask

  // Directed: lone outliers (a small one and S_MAX), and a symmetric pair around the mean
  task automatic test_outliers();
    gaps_on = 1'b1;
    send_set('{sample_word_t'(0), sample_word_t'(0), sample_word_t'(0), sample_word_t'(100)});
    send_set('{sample_word_t'(1), sample_word_t'(2), sample_word_t'(3)});
    send_set('{sample_word_t'(-1), S_MAX, sample_word_t'(-1), sample_word_t'(0)});
  endtask

  // Full buffer, then a set whose final sample is dropped
  task automatic test_buffer_limits();
    send_random_set(DEPTH);
    send_random_set(DEPTH + 1);
  endtask

  // Mostly short sets, now and then a long or overflowing one
  task automatic test_random_sets();
    int len;
    random_items = 0;
    while (random_items < 50) begin
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(40, DEPTH + 6)
                                         : $urandom_range(1, 10);
      send_random_set(len);
    end
  endtask

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_strobe) begin
      if (chosen_queue.size() == 0) begin
        flag_error($sformatf("unexpected result value=%0d end=%0b trunc=%0b",
                             result.chosen_value, result.end_of_run, result.truncated));
      end else begin
        want = chosen_queue.pop_front();
        if (result.chosen_value !== want.chosen_value ||
            result.end_of_run !== want.end_of_run ||
            result.truncated !== want.truncated) begin
          flag_error($sformatf(
            "expected value=%0d end=%0b trunc=%0b, got value=%0d end=%0b trunc=%0b",
            want.chosen_value, want.end_of_run, want.truncated,
            result.chosen_value, result.end_of_run, result.truncated));
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("farthest_from_mean_select_core_tb: errors");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_extremes();
    test_extreme_pair_tie();
    test_all_equal();
    test_outliers();
    test_buffer_limits();
    test_random_sets();

    @(negedge clk);
    start <= 1'b0;

    // Drain, then give the selection passes time to show any extra result
    while (chosen_queue.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 20) @(posedge clk);

    if (error_count == 0 && chosen_queue.size() == 0) begin
      $display("farthest_from_mean_select_core_tb: clean");
    end else begin
      $display("farthest_from_mean_select_core_tb: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/ffms_pkg.sv
rtl/ffms_ram.sv
rtl/farthest_from_mean_select_core.sv
tb/sv/farthest_from_mean_select_core_tb.sv
